/* sv/btb_pkg.sv */
// ----------------------------------------------------------------------------
// btb_pkg
// Shared constants and types for the two-level branch target buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package btb_pkg;

	// Table geometry
	localparam int ENTRIES       = 32;
	localparam int ENTRY_W       = 5;
	localparam int MAX_HISTORY   = 8;
	localparam int MAX_TAG       = 30;
	localparam int PC_IDX_LSB    = 2;
	localparam int MID_SHIFT     = 16;
	localparam int TABLE_SIZE    = 256;
	localparam int WORDS_PER_ENT = 8;
	localparam int WORD_W        = 64;
	localparam logic [31:0] FLUSH_PENALTY = 32'd2;

	// Stream and configuration widths
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 104;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_HIST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_TABLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHARE_MODE   = 3'd6;

	// Operation codes
	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	// Share modes
	localparam logic [1:0] SHARE_LOW = 2'd1;
	localparam logic [1:0] SHARE_MID = 2'd2;

	typedef struct packed {
		logic [2:0] index_bits;
		logic [4:0] tag_bits;
		logic [3:0] history_bits;
		logic [1:0] default_state;
		logic       global_history;
		logic       global_table;
		logic [1:0] share_mode;
	} cfg_t;

endpackage

`default_nettype wire

/* sv/btb_two_level_branch_predictor_top.sv */
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_top
// Direct-mapped branch target buffer with a two-level direction predictor.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   tuser: operation; tdata: pc, target, taken
// m_*       out        m_tvalid/m_tready   tdata: taken, target, branch and flush counts
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// One item at a time goes through a read-modify-write sequencer. A predict miss
// goes from S_META to S_OUT; a hit reads its counter in S_CRD and uses it in
// S_CALC; an update miss first runs S_FILL, which rewrites eight 64-bit counter
// words through the single write port of the counter memory, then goes on as a
// hit. S_IDLE accepts the next transfer. Reset is asynchronous and needs no
// clearing pass. A stalled output only holds the sequencer once the next result
// is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module btb_two_level_branch_predictor_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// tdata: branch_pc[31:0], resolved_target[63:32], resolved_taken[64], zero fill
	input  wire logic [btb_pkg::S_DATA_W-1:0]     s_tdata,
	// tuser: operation
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// tdata: predict_taken[0], predicted_target[32:1], branch_count[64:33],
	// flush_count[96:65], zero fill
	output logic [btb_pkg::M_DATA_W-1:0]          m_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [btb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [btb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import btb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_META, S_FILL, S_CRD, S_CALC, S_OUT
	} state_t;

	state_t state_q;
	cfg_t   cfg_q;

	// Item registers
	logic                op_q, tkn_q, hit_q;
	logic [31:0]         pc_q, tgt_q, etgt_q;
	logic [ENTRY_W-1:0]  e_q;
	logic [MAX_TAG-1:0]  tag_q;
	logic [7:0]          h_q;
	logic [2:0]          fill_cnt_q;
	logic                res_taken_q;
	logic [31:0]         res_target_q;
	logic [31:0]         branches_q, flush_q;

	// Small state in flops
	logic [ENTRIES-1:0]     valid_q;
	logic [MAX_HISTORY-1:0] hist_q [ENTRIES];
	logic [MAX_HISTORY-1:0] shist_q;
	logic [TABLE_SIZE-1:0]  sh_vld_q;

	// Memories and their read registers
	logic [31+MAX_TAG:0]   meta_mem [ENTRIES];
	logic [WORD_W-1:0]     ent_mem [ENTRIES*WORDS_PER_ENT];
	logic [1:0]            sh_mem [TABLE_SIZE];
	logic [31+MAX_TAG:0]   meta_rd_q;
	logic [WORD_W-1:0]     ent_rd_q;
	logic [1:0]            sh_rd_q;
	logic                  sh_vld_rd_q;

	// Incoming item fields
	logic        in_op, in_tkn;
	logic [31:0] in_pc, in_tgt;
	assign in_op  = s_tuser;
	assign in_pc  = s_tdata[31:0];
	assign in_tgt = s_tdata[63:32];
	assign in_tkn = s_tdata[64];

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	logic s_xfer;
	assign s_xfer = s_tvalid && s_tready;

	// Index and tag from the incoming pc
	logic [2:0]          idx_len;
	logic [2:0]          start;
	logic [5:0]          tag_len;
	logic [31:0]         idx_full, tag_full;
	logic [ENTRY_W-1:0]  in_e;
	logic [MAX_TAG-1:0]  in_tag;
	always_comb begin
		idx_len  = (cfg_q.index_bits > 3'd5) ? 3'd5 : cfg_q.index_bits;
		start    = 3'(PC_IDX_LSB) + idx_len;
		tag_len  = (cfg_q.tag_bits > 5'(MAX_TAG)) ? 6'(MAX_TAG) : {1'b0, cfg_q.tag_bits};
		if (tag_len > 6'd32 - {3'd0, start}) tag_len = 6'd32 - {3'd0, start};
		idx_full = (in_pc >> PC_IDX_LSB) & ((32'd1 << idx_len) - 32'd1);
		in_e     = idx_full[ENTRY_W-1:0];
		tag_full = (in_pc >> start) & ((32'd1 << tag_len) - 32'd1);
		in_tag   = tag_full[MAX_TAG-1:0];
	end

	// History mask and counter index
	logic [3:0]             hist_len;
	logic [MAX_HISTORY-1:0] hmask, hsel, cnt_idx;
	logic [31:0]            pc_lo, pc_mid;
	always_comb begin
		hist_len = (cfg_q.history_bits == 4'd0) ? 4'd1 :
			(cfg_q.history_bits > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : cfg_q.history_bits;
		hmask    = 8'((9'd1 << hist_len) - 9'd1);
		hsel     = cfg_q.global_history ? shist_q : hist_q[e_q];
		cnt_idx  = hsel & hmask;
		pc_lo    = pc_q >> PC_IDX_LSB;
		pc_mid   = pc_q >> MID_SHIFT;
		if (cfg_q.global_table) begin
			if (cfg_q.share_mode == SHARE_LOW) cnt_idx = cnt_idx ^ (pc_lo[7:0] & hmask);
			else if (cfg_q.share_mode == SHARE_MID) cnt_idx = cnt_idx ^ (pc_mid[7:0] & hmask);
		end
	end

	// Tag compare on the entry read back
	logic meta_hit;
	assign meta_hit = valid_q[e_q] && (meta_rd_q[MAX_TAG-1:0] == tag_q);

	// Selected counter and its trained value
	logic [5:0]        cnt_off;
	logic [1:0]        cnt, cnt_new;
	logic [WORD_W-1:0] ent_wword;
	always_comb begin
		cnt_off = {h_q[4:0], 1'b0};
		cnt     = cfg_q.global_table ? (sh_vld_rd_q ? sh_rd_q : 2'd1) : ent_rd_q[cnt_off +: 2];
		if (tkn_q) cnt_new = (cnt == 2'd3) ? cnt : cnt + 2'd1;
		else       cnt_new = (cnt == 2'd0) ? cnt : cnt - 2'd1;
		ent_wword = ent_rd_q;
		ent_wword[cnt_off +: 2] = cnt_new;
	end

	logic [MAX_HISTORY-1:0] hist_next;
	assign hist_next = (({hsel[MAX_HISTORY-2:0], 1'b0}) | {7'd0, tkn_q}) & hmask;

	// Memory control
	logic meta_we, ent_we, sh_we;
	logic [7:0] ent_waddr;
	logic [WORD_W-1:0] ent_wdata;
	always_comb begin
		meta_we   = (state_q == S_META) && (op_q == OP_UPDATE) && !meta_hit;
		ent_we    = (state_q == S_FILL) ||
			((state_q == S_CALC) && (op_q == OP_UPDATE) && !cfg_q.global_table);
		sh_we     = (state_q == S_CALC) && (op_q == OP_UPDATE) && cfg_q.global_table;
		ent_waddr = (state_q == S_FILL) ? {e_q, fill_cnt_q} : {e_q, h_q[7:5]};
		ent_wdata = (state_q == S_FILL) ? {32{cfg_q.default_state}} : ent_wword;
	end

	// Entry tag and target memory
	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[e_q] <= {tgt_q, tag_q};
		if (s_xfer) meta_rd_q <= meta_mem[in_e];
	end

	// Per-entry counter memory, eight words per entry
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (state_q == S_CRD) ent_rd_q <= ent_mem[{e_q, cnt_idx[7:5]}];
	end

	// Shared counter memory
	always_ff @(posedge clk) begin
		if (sh_we) sh_mem[h_q] <= cnt_new;
		if (state_q == S_CRD) sh_rd_q <= sh_mem[cnt_idx];
	end

	// Sequencer, configuration and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_q        <= '{index_bits: 3'd5, tag_bits: 5'd0, history_bits: 4'd1,
				default_state: 2'd1, global_history: 1'b0, global_table: 1'b0,
				share_mode: 2'd0};
			valid_q      <= '0;
			for (int i = 0; i < ENTRIES; i++) hist_q[i] <= '0;
			shist_q      <= '0;
			sh_vld_q     <= '0;
			sh_vld_rd_q  <= 1'b0;
			branches_q   <= '0;
			flush_q      <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			op_q         <= OP_PREDICT;
			tkn_q        <= 1'b0;
			hit_q        <= 1'b0;
			pc_q         <= '0;
			tgt_q        <= '0;
			etgt_q       <= '0;
			e_q          <= '0;
			tag_q        <= '0;
			h_q          <= '0;
			fill_cnt_q   <= '0;
			res_taken_q  <= 1'b0;
			res_target_q <= '0;
		end else begin
			// Configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_INDEX_BITS:   cfg_q.index_bits     <= cfg_data[2:0];
					REG_TAG_BITS:     cfg_q.tag_bits       <= cfg_data[4:0];
					REG_HISTORY_BITS: cfg_q.history_bits   <= cfg_data[3:0];
					REG_DEFAULT:      cfg_q.default_state  <= cfg_data[1:0];
					REG_GLOBAL_HIST:  cfg_q.global_history <= cfg_data[0];
					REG_GLOBAL_TABLE: cfg_q.global_table   <= cfg_data[0];
					REG_SHARE_MODE:   cfg_q.share_mode     <= cfg_data[1:0];
					default: ;
				endcase
			end

			// Output register drains independently unless a new result is loaded
			if (m_tvalid && m_tready && (state_q != S_OUT)) m_tvalid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						op_q    <= in_op;
						pc_q    <= in_pc;
						tgt_q   <= in_tgt;
						tkn_q   <= in_tkn;
						e_q     <= in_e;
						tag_q   <= in_tag;
						state_q <= S_META;
					end
				end
				S_META: begin
					hit_q  <= meta_hit;
					etgt_q <= meta_rd_q[31+MAX_TAG:MAX_TAG];
					if (op_q == OP_PREDICT) begin
						if (meta_hit) begin
							state_q <= S_CRD;
						end else begin
							res_taken_q  <= 1'b0;
							res_target_q <= pc_q + 32'd4;
							state_q      <= S_OUT;
						end
					end else begin
						branches_q <= branches_q + 32'd1;
						if (meta_hit) begin
							state_q <= S_CRD;
						end else begin
							valid_q[e_q] <= 1'b1;
							hist_q[e_q]  <= '0;
							fill_cnt_q   <= '0;
							state_q      <= S_FILL;
						end
					end
				end
				S_FILL: begin
					fill_cnt_q <= fill_cnt_q + 3'd1;
					if (fill_cnt_q == 3'(WORDS_PER_ENT - 1)) state_q <= S_CRD;
				end
				S_CRD: begin
					h_q         <= cnt_idx;
					sh_vld_rd_q <= sh_vld_q[cnt_idx];
					state_q     <= S_CALC;
				end
				S_CALC: begin
					if (op_q == OP_PREDICT) begin
						res_taken_q  <= cnt[1];
						res_target_q <= cnt[1] ? etgt_q : pc_q + 32'd4;
					end else begin
						res_taken_q  <= 1'b0;
						res_target_q <= '0;
						if (cnt[1] != tkn_q) flush_q <= flush_q + FLUSH_PENALTY;
						if (cfg_q.global_table) sh_vld_q[h_q] <= 1'b1;
						if (cfg_q.global_history) shist_q <= hist_next;
						else hist_q[e_q] <= hist_next;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'd0, flush_q, branches_q, res_target_q, res_taken_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_fill_only_on_install: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (op_q == OP_UPDATE) && !hit_q)
		else $error("counter fill outside an install");

	a_fill_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) && (fill_cnt_q == 3'(WORDS_PER_ENT - 1)) |=> (state_q == S_CRD))
		else $error("install fill did not end after the last word");

	a_branch_step: assert property (@(posedge clk) disable iff (!arst_n)
		(branches_q != $past(branches_q)) |-> (branches_q == $past(branches_q) + 32'd1)
			&& ($past(state_q) == S_META))
		else $error("branch count moved outside an update");

	a_flush_step: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q != $past(flush_q)) |-> (flush_q == $past(flush_q) + FLUSH_PENALTY)
			&& ($past(state_q) == S_CALC))
		else $error("flush count moved by a wrong step");

	a_hit_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) && (op_q == OP_PREDICT) |-> hit_q)
		else $error("predict reached the counter stage on a miss");

endmodule

`default_nettype wire
